@@ rtl/core/sfr_pkg.sv @@
// Shared types and constants for the stream find-and-replace block.
// Used by sfr_front, sfr_queue, sfr_back and stream_find_replace.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	// widest pattern or replacement string, in bytes
	localparam int MAX_BYTES = 8;
	localparam int SNAP_W = MAX_BYTES * 8;

	// length fields, wide enough to hold MAX_BYTES itself
	localparam int LEN_W = 4;

	// configuration port
	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 2;

	// default sizes
	localparam int DEF_MAX_PATTERN = 8;
	localparam int DEF_MAX_REPLACEMENT = 8;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_e;

	// one emit command: send len bytes of snap, low byte first
	typedef struct packed {
		logic [SNAP_W-1:0] snap;
		logic [LEN_W-1:0]  len;
		logic              line_done;
		logic              had_match;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/stream_find_replace.sv @@
// Stream find-and-replace, top level: front end, command queue, back end.
// Path: a word's command goes into the queue, then the back end's command register, then the output register.
// Throughput: the front takes one word a cycle while the two-entry queue has room;
// the back emits one result a cycle while out_stall is low, with no gap between
// commands, so a word's results go out back to back and a quiet word sends none.
// Reset: asynchronous, active low; clears control and configuration, window bytes stay.
`timescale 1ns / 1ps
`default_nettype none

module stream_find_replace #(
	parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN,
	parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          line_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic                          line_done,
	output logic                          line_had_match,
	output logic                          last
);
	import sfr_pkg::*;

	cmd_t push_cmd, head_cmd;
	logic push, q_full, pop, q_not_empty;

	// classify words into emit commands
	sfr_front #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.line_end  (line_end),
		.cmd       (push_cmd),
		.cmd_push  (push),
		.q_full    (q_full)
	);

	// decouple the two sides
	sfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.head      (head_cmd),
		.not_empty (q_not_empty)
	);

	// emit results
	sfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_head         (head_cmd),
		.q_pop          (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.line_done      (line_done),
		.line_had_match (line_had_match),
		.last           (last)
	);

`ifndef SYNTH
	// a bare marker only ever closes a line
	a_bare_closes_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (line_done && last && out_byte == 8'h00))
		else $error("bare marker not at line end");

	// line end is always the last result of its word
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_done) |-> last)
		else $error("line_done without last");

	// match flag only rides on the line's final result
	a_match_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_had_match) |-> line_done)
		else $error("line_had_match without line_done");

	// a full queue holds the input side
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !pop) |=> in_stall)
		else $error("input not stalled on full queue");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sfr_front.sv @@
// Front end: configuration registers, match window and classification.
// Turns each accepted word into at most one emit command; depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_front #(
	parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN,
	parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     in_byte,
	input  logic                           line_end,
	output sfr_pkg::cmd_t                  cmd,
	output logic                           cmd_push,
	input  logic                           q_full
);
	import sfr_pkg::*;

	localparam int REPL_BYTES = (MAX_REPLACEMENT > 0) ? MAX_REPLACEMENT : 1;

	// configuration
	logic [7:0]       pat_q [MAX_PATTERN];
	logic [LEN_W-1:0] pat_len_q;
	logic [7:0]       repl_q [REPL_BYTES];
	logic [LEN_W-1:0] repl_len_q;

	// window state
	logic [7:0]       win_q [MAX_PATTERN];
	logic [LEN_W-1:0] cnt_q;
	logic             match_seen_q;

	logic [LEN_W-1:0] plen, rlen, c0, c1, s_min;
	logic [7:0]       nw [MAX_PATTERN];
	logic [7:0]       shw [MAX_PATTERN];
	logic [MAX_PATTERN:0] pre_ok, ok;
	logic             full_match, accept, need_push;

	// effective lengths
	always_comb begin
		if (pat_len_q == '0)
			plen = LEN_W'(1);
		else if (pat_len_q > LEN_W'(MAX_PATTERN))
			plen = LEN_W'(MAX_PATTERN);
		else
			plen = pat_len_q;
		rlen = (repl_len_q > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : repl_len_q;
	end

	// append the new byte, then find the smallest head drop that leaves a proper prefix
	always_comb begin
		c0 = (cnt_q >= plen) ? '0 : cnt_q;
		c1 = c0 + LEN_W'(1);
		for (int j = 0; j < MAX_PATTERN; j++) begin
			nw[j] = (LEN_W'(j) == c0) ? in_byte : win_q[j];
		end
		for (int s = 0; s <= MAX_PATTERN; s++) begin
			pre_ok[s] = 1'b1;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (s + j < MAX_PATTERN) begin
					if (LEN_W'(s + j) < c1 && nw[s + j] != pat_q[j])
						pre_ok[s] = 1'b0;
				end
			end
			ok[s] = pre_ok[s];
			if (LEN_W'(s) <= c1 && (c1 - LEN_W'(s)) >= plen)
				ok[s] = 1'b0;
		end
		full_match = (c1 == plen) && pre_ok[0];
		s_min = c1;
		for (int s = MAX_PATTERN; s >= 0; s--) begin
			if (ok[s] && LEN_W'(s) <= c1)
				s_min = LEN_W'(s);
		end
		for (int j = 0; j < MAX_PATTERN; j++) begin
			shw[j] = nw[j];
			for (int s = 1; s <= MAX_PATTERN; s++) begin
				if (j + s < MAX_PATTERN && LEN_W'(s) == s_min)
					shw[j] = nw[j + s];
			end
		end
	end

	// emit command for this word
	always_comb begin
		for (int j = 0; j < MAX_BYTES; j++) begin
			if (full_match)
				cmd.snap[j*8 +: 8] = (j < REPL_BYTES) ? repl_q[j] : 8'h00;
			else
				cmd.snap[j*8 +: 8] = (j < MAX_PATTERN) ? nw[j] : 8'h00;
		end
		if (full_match)
			cmd.len = rlen;
		else
			cmd.len = line_end ? c1 : s_min;
		cmd.line_done = line_end;
		cmd.had_match = line_end & (match_seen_q | full_match);
	end

	assign need_push = line_end || (cmd.len != '0);
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign cmd_push  = accept && need_push;

	// configuration registers and window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PATTERN; j++) pat_q[j] <= 8'h00;
			for (int j = 0; j < REPL_BYTES; j++) repl_q[j] <= 8'h00;
			pat_len_q    <= LEN_W'(1);
			repl_len_q   <= '0;
			cnt_q        <= '0;
			match_seen_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_PATTERN_BYTES: begin
					for (int j = 0; j < MAX_PATTERN; j++) pat_q[j] <= cfg_data[j*8 +: 8];
					cnt_q <= '0;
				end
				REG_PATTERN_LENGTH: begin
					pat_len_q <= cfg_data[LEN_W-1:0];
					cnt_q     <= '0;
				end
				REG_REPLACEMENT_BYTES: begin
					for (int j = 0; j < REPL_BYTES; j++) repl_q[j] <= cfg_data[j*8 +: 8];
				end
				REG_REPLACEMENT_LENGTH: begin
					repl_len_q <= cfg_data[LEN_W-1:0];
				end
				default: ;
			endcase
		end else if (accept) begin
			if (line_end || full_match)
				cnt_q <= '0;
			else
				cnt_q <= c1 - s_min;
			if (line_end)
				match_seen_q <= 1'b0;
			else if (full_match)
				match_seen_q <= 1'b1;
		end
	end

	// held window bytes, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int j = 0; j < MAX_PATTERN; j++) win_q[j] <= shw[j];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sfr_queue.sv @@
// Short command queue between front and back ends.
// Depends on sfr_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module sfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output sfr_pkg::cmd_t head,
	output logic          not_empty
);
	import sfr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

@@ rtl/core/sfr_back.sv @@
// Back end: walks one emit command at a time into the output register.
// Depends on sfr_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module sfr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  sfr_pkg::cmd_t q_head,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          line_done,
	output logic          line_had_match,
	output logic          last
);
	import sfr_pkg::*;

	// command being emitted
	logic              cur_valid_q;
	logic [SNAP_W-1:0] snap_q;
	logic [LEN_W-1:0]  rem_q;
	logic              bare_q, done_q, match_q;

	// output register
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              byte_valid_q, line_done_q, had_match_q, last_q;

	logic out_free, cur_last, emit;

	assign out_free = !out_valid_q || !out_stall;
	assign cur_last = (rem_q == LEN_W'(1));
	assign emit     = cur_valid_q && out_free;
	assign q_pop    = q_not_empty && (!cur_valid_q || (emit && cur_last));

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				rem_q       <= (q_head.len == '0) ? LEN_W'(1) : q_head.len;
			end else if (emit) begin
				rem_q <= rem_q - LEN_W'(1);
				if (cur_last)
					cur_valid_q <= 1'b0;
			end
			if (out_free)
				out_valid_q <= cur_valid_q;
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			snap_q  <= q_head.snap;
			bare_q  <= (q_head.len == '0);
			done_q  <= q_head.line_done;
			match_q <= q_head.had_match;
		end else if (emit) begin
			snap_q <= {8'h00, snap_q[SNAP_W-1:8]};
		end
		if (emit) begin
			out_byte_q   <= bare_q ? 8'h00 : snap_q[7:0];
			byte_valid_q <= !bare_q;
			line_done_q  <= cur_last && done_q;
			had_match_q  <= cur_last && done_q && match_q;
			last_q       <= cur_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign byte_valid     = byte_valid_q;
	assign line_done      = line_done_q;
	assign line_had_match = had_match_q;
	assign last           = last_q;

endmodule

`default_nettype wire

@@ tb/stream_find_replace_checker.sv @@
// Checker for stream_find_replace: watches the config port and both word channels,
// predicts the output text and compares every accepted result word.
// Depends on sfr_pkg for the register index enum and port widths.
`timescale 1ns / 1ps

module stream_find_replace_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          line_end,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [7:0]                    out_byte,
	input  logic                          byte_valid,
	input  logic                          line_done,
	input  logic                          line_had_match,
	input  logic                          last,
	output int                            failures,
	output int                            outstanding
);
	import sfr_pkg::*;

	// one output word as the block should present it
	typedef struct packed {
		logic [7:0] text;
		logic       carries;
		logic       done;
		logic       matched;
		logic       tail;
	} text_result_t;

	// shadow copy of the configuration registers
	logic [63:0] pattern_q = '0;
	logic [3:0]  pattern_len_q = 4'd1;
	logic [63:0] repl_q = '0;
	logic [3:0]  repl_len_q = '0;

	// shadow copy of the match window
	logic [7:0] held [0:7];
	int         held_count = 0;
	logic       line_matched = 1'b0;

	text_result_t expected_text [$];
	int           mismatch_count = 0;
	int           queued = 0;

	assign failures = mismatch_count;
	assign outstanding = queued;

	function automatic text_result_t text_of(input logic [7:0] b);
		return '{text: b, carries: 1'b1, default: 1'b0};
	endfunction

	// held bytes equal the head of the pattern
	function automatic bit held_is_prefix();
		int i;
		for (i = 0; i < held_count; i++) begin
			if (held[i] !== pattern_q[8*i +: 8])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the window by one text byte and queue the words it releases
	function automatic void replace_step(input logic [7:0] b, input logic eol);
		text_result_t res [0:8];
		int n;
		int plen;
		int rlen;
		int i;
		n = 0;
		plen = (pattern_len_q == 0) ? 1 : (pattern_len_q > 8) ? 8 : int'(pattern_len_q);
		rlen = (repl_len_q > 8) ? 8 : int'(repl_len_q);

		if (held_count >= plen)
			held_count = 0;
		held[held_count] = b;
		held_count++;

		if (held_count == plen && held_is_prefix()) begin
			for (i = 0; i < rlen; i++) begin
				res[n] = text_of(repl_q[8*i +: 8]);
				n++;
			end
			held_count = 0;
			line_matched = 1'b1;
		end else begin
			// release from the head until the rest could still start a match
			while (held_count > 0 && (held_count >= plen || !held_is_prefix())) begin
				res[n] = text_of(held[0]);
				n++;
				for (i = 1; i < held_count; i++)
					held[i-1] = held[i];
				held_count--;
			end
		end

		// line end flushes the window; a bare marker if nothing else went out
		if (eol) begin
			for (i = 0; i < held_count; i++) begin
				res[n] = text_of(held[i]);
				n++;
			end
			held_count = 0;
			if (n == 0) begin
				res[0] = '0;
				n = 1;
			end
			res[n-1].done = 1'b1;
			res[n-1].matched = line_matched;
			line_matched = 1'b0;
		end

		if (n > 0)
			res[n-1].tail = 1'b1;
		for (i = 0; i < n; i++)
			expected_text.push_back(res[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		text_result_t got;
		text_result_t want;
		if (!arst_n) begin
			pattern_q = '0;
			pattern_len_q = 4'd1;
			repl_q = '0;
			repl_len_q = '0;
			held_count = 0;
			line_matched = 1'b0;
			expected_text.delete();
		end else begin
			// result side first: a word accepted now cannot come from this edge's input
			if (out_valid && !out_stall) begin
				got = '{out_byte, byte_valid, line_done, line_had_match, last};
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected word: byte=%h valid=%b done=%b match=%b last=%b",
						$time, got.text, got.carries, got.done, got.matched, got.tail);
					mismatch_count++;
				end else begin
					want = expected_text.pop_front();
					if (got.text !== want.text || got.carries !== want.carries ||
							got.done !== want.done || got.matched !== want.matched ||
							got.tail !== want.tail) begin
						$display("%0t: mismatch: expected byte=%h valid=%b done=%b match=%b last=%b",
							$time, want.text, want.carries, want.done, want.matched, want.tail);
						$display("%0t:           actual   byte=%h valid=%b done=%b match=%b last=%b",
							$time, got.text, got.carries, got.done, got.matched, got.tail);
						mismatch_count++;
					end
				end
			end

			// register writes; a pattern change drops the held bytes
			if (cfg_we) begin
				case (cfg_reg_e'(cfg_index))
					REG_PATTERN_BYTES: begin
						pattern_q = cfg_data;
						held_count = 0;
					end
					REG_PATTERN_LENGTH: begin
						pattern_len_q = cfg_data[3:0];
						held_count = 0;
					end
					REG_REPLACEMENT_BYTES: repl_q = cfg_data;
					REG_REPLACEMENT_LENGTH: repl_len_q = cfg_data[3:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall)
				replace_step(in_byte, line_end);
		end
		queued = expected_text.size();
	end

endmodule

@@ tb/stream_find_replace_test.sv @@
// Top of the stream_find_replace testbench: clock, reset, config writes, text stimulus
// with random idling on both channels, a watchdog and the verdict.
// Depends on sfr_pkg, stream_find_replace and stream_find_replace_checker.
`timescale 1ns / 1ps

module stream_find_replace_test;
	import sfr_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 25;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           in_byte = '0;
	logic                 line_end = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           out_byte;
	logic                 byte_valid;
	logic                 line_done;
	logic                 line_had_match;
	logic                 last;

	int failures;
	int outstanding;

	// pattern as last written, for building text that hits it
	logic [63:0] cur_pattern = '0;
	int          cur_plen = 1;

	// receiver control
	bit rx_idles = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int rx_gap = 0;
	int idle_cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	stream_find_replace DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.line_done(line_done),
		.line_had_match(line_had_match),
		.last(last)
	);

	stream_find_replace_checker sfr_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.line_done(line_done),
		.line_had_match(line_had_match),
		.last(last),
		.failures(failures),
		.outstanding(outstanding)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic int clamp_plen(input logic [3:0] v);
		if (v == 0)
			return 1;
		if (v > 8)
			return 8;
		return int'(v);
	endfunction

	// receiver: one long hold on request, else random stalls when enabled
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else if (rx_idles && $urandom_range(0, 3) == 0) begin
				rx_gap = gap_len() - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: too long with no word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// offer one word and wait for it to be taken; valid stays high on return
	task automatic send_word(input logic [7:0] b, input logic eol);
		in_byte <= b;
		line_end <= eol;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		if ($urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(negedge clk);
		end
	endtask

	// drain all expected words, then idle with valid low so the pipeline is clear
	task automatic settle();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input bit touch_pattern, input logic [63:0] pat,
			input logic [63:0] plen_word, input logic [63:0] rep, input logic [63:0] rlen_word);
		if (touch_pattern) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_PATTERN_BYTES;
			cfg_data <= pat;
			@(negedge clk);
			cfg_index <= REG_PATTERN_LENGTH;
			cfg_data <= plen_word;
			@(negedge clk);
			cur_pattern = pat;
			cur_plen = clamp_plen(plen_word[3:0]);
		end
		cfg_we <= 1'b1;
		cfg_index <= REG_REPLACEMENT_BYTES;
		cfg_data <= rep;
		@(negedge clk);
		cfg_index <= REG_REPLACEMENT_LENGTH;
		cfg_data <= rlen_word;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// text mostly built from whole or partial copies of the pattern, plus noise
	task automatic run_text(input int count, input bit gaps);
		int sent;
		int sel;
		int len;
		int k;
		int pos;
		logic [7:0] b;
		sent = 0;
		while (sent < count) begin
			sel = $urandom_range(0, 7);
			if (sel < 4)
				len = cur_plen;
			else if (sel < 6)
				len = $urandom_range(1, cur_plen);
			else
				len = 1;
			for (k = 0; k < len && sent < count; k++) begin
				if (sel < 6) begin
					b = cur_pattern[8*k +: 8];
				end else if ($urandom_range(0, 1) == 0) begin
					pos = $urandom_range(0, 7);
					b = cur_pattern[8*pos +: 8];
				end else begin
					b = 8'($urandom);
				end
				send_word(b, $urandom_range(0, 9) == 0);
				sent++;
				if (gaps)
					pause_sender();
			end
		end
	endtask

	initial begin : stimulus
		logic [63:0] pat;
		logic [63:0] rep;
		logic [63:0] plen_word;
		logic [63:0] rlen_word;
		logic [7:0]  base;
		int          ph;
		int          k;
		int          sel;
		int          plen;
		int          rlen;
		bit          touch;

		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// out of reset: one zero byte is the pattern and matches are deleted,
		// so a line ending on a match gives a bare marker
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'h41, 1'b1);
		settle();

		// "abc" -> "XY": match, mismatch with recheck, then a partial match left held
		configure(1'b1, 64'h636261, 64'd3, 64'h5958, 64'd2);
		send_word(8'h61, 1'b0);
		send_word(8'h62, 1'b0);
		send_word(8'h63, 1'b0);
		send_word(8'h61, 1'b0);
		send_word(8'h62, 1'b0);
		send_word(8'h61, 1'b0);
		send_word(8'h62, 1'b0);
		send_word(8'h63, 1'b0);
		send_word(8'h78, 1'b1);
		send_word(8'h61, 1'b0);
		send_word(8'h62, 1'b0);
		settle();

		// pattern write mid-line drops "ab"; zero length taken as one,
		// replacement length above the maximum taken as the maximum
		configure(1'b1, '1, 64'd0, 64'h0123456789ABCDEF, 64'd15);
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b0);
		settle();

		// pattern length above the maximum; one full-window match, then a held byte flushed
		configure(1'b1, {8{8'h61}}, 64'd15, 64'h5A, 64'd1);
		repeat (8) send_word(8'h61, 1'b0);
		send_word(8'h61, 1'b1);
		settle();

		// random phases, some with only the replacement changed mid-line
		for (ph = 0; ph < PHASES; ph++) begin
			base = 8'($urandom);
			for (k = 0; k < 8; k++) begin
				if ($urandom_range(0, 2) != 0)
					pat[8*k +: 8] = base + 8'($urandom_range(0, 1));
				else
					pat[8*k +: 8] = 8'($urandom);
			end
			rep = {32'($urandom), 32'($urandom)};
			sel = $urandom_range(0, 11);
			// phase 2 uses a one-byte pattern and a non-empty replacement,
			// so every word gives a result and the block fills behind the hold
			if (ph == 0)
				plen = 8;
			else if (ph == 1 || ph == 2)
				plen = 1;
			else if (sel == 0)
				plen = 0;
			else if (sel == 1)
				plen = $urandom_range(9, 15);
			else
				plen = $urandom_range(1, 8);
			if (ph == 0)
				rlen = 8;
			else if (ph == 1)
				rlen = 0;
			else if (ph == 2)
				rlen = $urandom_range(1, 8);
			else if ($urandom_range(0, 9) == 0)
				rlen = $urandom_range(9, 15);
			else
				rlen = $urandom_range(0, 8);
			plen_word = {32'($urandom), 28'($urandom), 4'(plen)};
			rlen_word = {32'($urandom), 28'($urandom), 4'(rlen)};
			touch = (ph < 2) || ($urandom_range(0, 3) != 0);
			configure(touch, pat, plen_word, rep, rlen_word);

			// phase 0 runs without idling, phase 2 fills the block behind a long hold
			rx_idles = (ph > 2) ? ($urandom_range(0, 3) != 0) : (ph == 1);
			if (ph == 2)
				hold_request = 1'b1;
			run_text(PHASE_WORDS, (ph > 2) ? ($urandom_range(0, 3) != 0) : (ph == 1));
			settle();
		end

		if (failures == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
